>>> design/bdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants of the button press classifier
// Holds field widths, register defaults, register indexes, event kinds and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int TIME_W      = 32;
  localparam int RAW_W       = 4;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_BUTTONS_DEF = 4;

  // register defaults after reset
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_GUARD_RESET = 16'd300;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1500;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_GUARD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

  // event kinds
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } bdpc_state_t;

  typedef struct packed {
    logic load;   // latch the poll and restart the scan
    logic step;   // evaluate one button
    logic pop;    // drop the event word just taken
  } bdpc_cmd_t;

  typedef struct packed {
    logic scan_last;     // button under evaluation is the final one
    logic event_now;     // button under evaluation raises an event
    logic pending_any;   // events already queued from this poll
    logic pending_last;  // the event on the output is the final one
  } bdpc_status_t;

endpackage

>>> design/bdpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_ctrl: sequencing state machine
// Takes a poll, walks the buttons one per cycle, then hands out the queued
// event words until the last one has been taken.
// ----------------------------------------------------------------------------
module bdpc_ctrl
  import bdpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         poll_valid,
  output logic         poll_stall,
  output logic         event_valid,
  input  logic         event_stall,
  input  bdpc_status_t status,
  output bdpc_cmd_t    cmd
);

  bdpc_state_t state, state_next;

  // hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequence the scan and the event hand-out
  always_comb begin
    state_next  = state;
    cmd         = '0;
    poll_stall  = 1'b1;
    event_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        poll_stall = 1'b0;
        if (poll_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          if (status.pending_any || status.event_now) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        event_valid = 1'b1;
        if (!event_stall) begin
          cmd.pop = 1'b1;
          if (status.pending_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/bdpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_datapath: per-button state, evaluation unit and event queue
// Keeps the configuration registers and the state of every button, evaluates
// the button picked by the scan counter and queues one event bit per button.
// ----------------------------------------------------------------------------
module bdpc_datapath
  import bdpc_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [TIME_W-1:0]    now_ms,
  input  logic [RAW_W-1:0]     raw_pressed,
  input  bdpc_cmd_t            cmd,
  output bdpc_status_t         status,
  output logic [IDX_W-1:0]     button_index,
  output logic                 press_kind,
  output logic                 last_event
);

  logic [CFG_W-1:0] debounce_time;
  logic [CFG_W-1:0] hold_guard_time;
  logic [CFG_W-1:0] long_press_time;

  logic [TIME_W-1:0] poll_time;
  logic [RAW_W-1:0]  poll_raw;
  logic [IDX_W-1:0]  scan_idx;

  logic              raw_level       [NUM_BUTTONS];
  logic [TIME_W-1:0] change_time     [NUM_BUTTONS];
  logic              debounced_level [NUM_BUTTONS];
  logic [TIME_W-1:0] press_time      [NUM_BUTTONS];
  logic [TIME_W-1:0] release_time    [NUM_BUTTONS];
  logic              long_done       [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0] pending;
  logic [NUM_BUTTONS-1:0] kind;

  logic [NUM_BUTTONS-1:0] raw_ext;
  logic                   raw_now;
  logic                   changed;
  logic [TIME_W-1:0]      since_change;
  logic [TIME_W-1:0]      since_release;
  logic [TIME_W-1:0]      since_press;
  logic                   stable;
  logic                   want;
  logic                   guarded;
  logic                   accept;
  logic                   accept_press;
  logic                   deb_new;
  logic                   long_done_new;
  logic                   short_evt;
  logic                   long_evt;

  logic [IDX_W-1:0]       first_idx;
  logic [NUM_BUTTONS-1:0] first_oh;

  // buttons beyond the input width read as not pressed
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_raw
    if (b < RAW_W) begin : g_in
      assign raw_ext[b] = poll_raw[b];
    end else begin : g_none
      assign raw_ext[b] = 1'b0;
    end
  end

  // evaluate the button under the scan counter
  always_comb begin
    raw_now       = raw_ext[scan_idx];
    changed       = raw_now != raw_level[scan_idx];
    since_change  = poll_time - change_time[scan_idx];
    since_release = poll_time - release_time[scan_idx];
    since_press   = poll_time - press_time[scan_idx];
    stable        = changed ? (debounce_time == '0)
                            : (since_change >= TIME_W'(debounce_time));
    want          = stable && (debounced_level[scan_idx] != raw_now);
    guarded       = raw_now && (release_time[scan_idx] != '0) &&
                    (since_release < TIME_W'(hold_guard_time));
    accept        = want && !guarded;
    accept_press  = accept && raw_now;
    deb_new       = accept ? raw_now : debounced_level[scan_idx];
    long_done_new = accept_press ? 1'b0 : long_done[scan_idx];
    short_evt     = accept && !raw_now && !long_done[scan_idx];
    long_evt      = deb_new && !long_done_new &&
                    (accept_press ? (long_press_time == '0)
                                  : (since_press >= TIME_W'(long_press_time)));
  end

  // pick the lowest queued button
  always_comb begin
    first_idx = '0;
    for (int b = NUM_BUTTONS - 1; b >= 0; b--) begin
      if (pending[b]) begin
        first_idx = IDX_W'(b);
      end
    end
    first_oh = '0;
    first_oh[first_idx] = 1'b1;
  end

  assign button_index = first_idx;
  assign press_kind   = kind[first_idx];
  assign last_event   = (pending & ~first_oh) == '0;

  assign status.scan_last    = scan_idx == IDX_W'(NUM_BUTTONS - 1);
  assign status.event_now    = short_evt || long_evt;
  assign status.pending_any  = pending != '0;
  assign status.pending_last = last_event;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      hold_guard_time <= HOLD_GUARD_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_time   <= cfg_data;
        REG_HOLD_GUARD: hold_guard_time <= cfg_data;
        REG_LONG_PRESS: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // latch the poll word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      poll_time <= now_ms;
      poll_raw  <= raw_pressed;
    end
  end

  // advance the scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.load) begin
      scan_idx <= '0;
    end else if (cmd.step && !status.scan_last) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // update the state of the evaluated button
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        raw_level[b]       <= 1'b0;
        change_time[b]     <= '0;
        debounced_level[b] <= 1'b0;
        press_time[b]      <= '0;
        release_time[b]    <= '0;
        long_done[b]       <= 1'b0;
      end
    end else if (cmd.step) begin
      raw_level[scan_idx]       <= raw_now;
      debounced_level[scan_idx] <= deb_new;
      long_done[scan_idx]       <= long_done_new || long_evt;
      if (changed) begin
        change_time[scan_idx] <= poll_time;
      end
      if (accept_press) begin
        press_time[scan_idx] <= poll_time;
      end
      if (accept && !raw_now) begin
        release_time[scan_idx] <= poll_time;
      end
    end
  end

  // queue events and drop them as they are taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd.load) begin
      pending <= '0;
    end else if (cmd.step) begin
      pending[scan_idx] <= short_evt || long_evt;
    end else if (cmd.pop) begin
      pending <= pending & ~first_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      kind[scan_idx] <= long_evt ? KIND_LONG : KIND_SHORT;
    end
  end

endmodule

>>> design/button_debounce_press_classifier.sv
`timescale 1ns / 1ps
// A poll is evaluated one button per cycle through a single evaluation unit;
// its first event word appears in the next cycle after the last button.
// A new poll is taken only once all events of the previous one have been
// taken, so any stall on the event side also holds off the next poll.
// Reset (rst, synchronous): all button state clears, registers take defaults.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier: debounced short and long press events
// Top level joining the sequencing controller and the button datapath.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // poll channel
  input  logic                 poll_valid,
  output logic                 poll_stall,
  input  logic [TIME_W-1:0]    now_ms,
  input  logic [RAW_W-1:0]     raw_pressed,
  // event channel
  output logic                 event_valid,
  input  logic                 event_stall,
  output logic [IDX_W-1:0]     button_index,
  output logic                 press_kind,
  output logic                 last_event
);

  bdpc_cmd_t    cmd;
  bdpc_status_t status;

  // registers are always writable
  assign cfg_ready = 1'b1;

  bdpc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .poll_valid  (poll_valid),
    .poll_stall  (poll_stall),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .status      (status),
    .cmd         (cmd)
  );

  bdpc_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .now_ms       (now_ms),
    .raw_pressed  (raw_pressed),
    .cmd          (cmd),
    .status       (status),
    .button_index (button_index),
    .press_kind   (press_kind),
    .last_event   (last_event)
  );

endmodule
